// ===== rtl/core/dmap_pkg.sv =====
// ----------------------------------------------------------------------------
// dmap_pkg: shared types and constants of the OFDM data resource mapper
// Field widths, register indexes, config and result structs, and the
// free-symbol pick used by the config block and the address datapath.
// ----------------------------------------------------------------------------
package dmap_pkg;

    // limits of the grid
    localparam int MAX_LAYERS           = 8;
    localparam int MAX_SYMBOLS_PER_SLOT = 14;

    // field and state widths
    localparam int WORD_W     = 32;
    localparam int ADDR_W     = 27;
    localparam int DW_W       = 16;
    localparam int SC_W       = 12;
    localparam int WIS_W      = SC_W + 1;
    localparam int SPS_W      = 4;
    localparam int SYM_W      = SPS_W;
    localparam int MASK_W     = 14;
    localparam int FREE_W     = 16;
    localparam int STRIDE_W   = 24;
    localparam int NL_W       = 4;
    localparam int LAYER_W    = $clog2(MAX_LAYERS);
    localparam int ROW_W      = 16;
    localparam int SLOT_W     = WIS_W + SPS_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_WORDS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBCARR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RSV_MASK   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYERS     = 3'd6;

    // direction codes
    localparam logic DIR_ALLOCATE = 1'b0;
    localparam logic DIR_EXTRACT  = 1'b1;

    // effective configuration, zero and oversize values already folded
    typedef struct packed {
        logic                direction;
        logic [DW_W-1:0]     dw;
        logic [WIS_W-1:0]    row_words;
        logic [SPS_W-1:0]    sps;
        logic [FREE_W-1:0]   free;
        logic [STRIDE_W-1:0] stride;
        logic [NL_W-1:0]     nl;
        logic [SLOT_W-1:0]   slot_words;
        logic [SYM_W-1:0]    ff0;
        logic [SLOT_W-1:0]   start_base;
    } t_cfg;

    // one result word
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [ADDR_W-1:0] addr;
        logic              last;
    } t_result;

    // position of the datapath, for checks
    typedef struct packed {
        logic [LAYER_W-1:0] layer;
        logic [WIS_W-1:0]   wis;
        logic [DW_W-1:0]    done;
    } t_status;

    typedef struct packed {
        logic             found;
        logic [SYM_W-1:0] idx;
    } t_pick;

    // lowest data symbol at or above a start position
    function automatic t_pick first_free(logic [FREE_W-1:0] free, logic [SYM_W:0] from);
        t_pick p;
        p.found = 1'b0;
        p.idx   = '0;
        for (int i = FREE_W - 1; i >= 0; i--) begin
            if (free[i] && ((SYM_W + 1)'(i) >= from)) begin
                p.found = 1'b1;
                p.idx   = SYM_W'(i);
            end
        end
        return p;
    endfunction

endpackage

// ===== rtl/core/dmap_in_if.sv =====
// ----------------------------------------------------------------------------
// dmap_in_if: input word channel
// Valid/ready channel carrying one raw sample word.
// ----------------------------------------------------------------------------
interface dmap_in_if import dmap_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] sample_word;

    modport source (output valid, output sample_word, input ready);
    modport sink   (input valid, input sample_word, output ready);
endinterface

// ===== rtl/core/dmap_out_if.sv =====
// ----------------------------------------------------------------------------
// dmap_out_if: result word channel
// Valid/ready channel carrying a word, its target address and frame end.
// ----------------------------------------------------------------------------
interface dmap_out_if import dmap_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] out_word;
    logic [ADDR_W-1:0] target_address;
    logic              frame_last;

    modport source (output valid, output out_word, output target_address,
                    output frame_last, input ready);
    modport sink   (input valid, input out_word, input target_address,
                    input frame_last, output ready);
endinterface

// ===== rtl/core/dmap_cfg.sv =====
// ----------------------------------------------------------------------------
// dmap_cfg: configuration registers
// Holds the raw registers, folds zero and oversize values, and derives the
// free-symbol map and the per-slot word counts used by the datapath.
// ----------------------------------------------------------------------------
module dmap_cfg import dmap_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg,
    output t_cfg                  o_cfg_next,
    output logic                  o_restart
);

    logic                r_direction, n_direction;
    logic [DW_W-1:0]     r_dw, n_dw;
    logic [SC_W-1:0]     r_sc, n_sc;
    logic [SPS_W-1:0]    r_sps, n_sps;
    logic [MASK_W-1:0]   r_mask, n_mask;
    logic [STRIDE_W-1:0] r_stride, n_stride;
    logic [NL_W-1:0]     r_nl, n_nl;

    // fold raw values into the effective set
    function automatic t_cfg cfg_eff(logic dir, logic [DW_W-1:0] dw, logic [SC_W-1:0] sc,
                                     logic [SPS_W-1:0] sps, logic [MASK_W-1:0] mask,
                                     logic [STRIDE_W-1:0] stride, logic [NL_W-1:0] nl);
        t_cfg              c;
        logic [SC_W-1:0]   sc_e;
        logic [SPS_W-1:0]  sps_e;
        logic [FREE_W-1:0] full;
        logic [FREE_W-1:0] m;
        t_pick             p;
        c.direction = dir;
        c.dw        = (dw == '0) ? DW_W'(1) : dw;
        // a 12-bit field never exceeds the subcarrier limit
        sc_e        = (sc == '0) ? SC_W'(1) : sc;
        c.row_words = {sc_e, 1'b0};
        sps_e       = (sps == '0) ? SPS_W'(1) : sps;
        if (sps_e > SPS_W'(MAX_SYMBOLS_PER_SLOT)) begin
            sps_e = SPS_W'(MAX_SYMBOLS_PER_SLOT);
        end
        c.sps  = sps_e;
        full   = (FREE_W'(1) << sps_e) - FREE_W'(1);
        m      = FREE_W'(mask) & full;
        // a fully reserved slot means no reservation at all
        if (m == full) begin
            m = '0;
        end
        c.free     = full & ~m;
        c.stride   = (stride == '0) ? STRIDE_W'(1) : stride;
        c.nl       = (nl == '0) ? NL_W'(1) : nl;
        if (c.nl > NL_W'(MAX_LAYERS)) begin
            c.nl = NL_W'(MAX_LAYERS);
        end
        c.slot_words = SLOT_W'(sps_e) * SLOT_W'(c.row_words);
        p            = first_free(c.free, '0);
        c.ff0        = p.idx;
        c.start_base = SLOT_W'(p.idx) * SLOT_W'(c.row_words);
        return c;
    endfunction

    // register write decode
    always_comb begin
        n_direction = r_direction;
        n_dw        = r_dw;
        n_sc        = r_sc;
        n_sps       = r_sps;
        n_mask      = r_mask;
        n_stride    = r_stride;
        n_nl        = r_nl;
        o_restart   = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DIRECTION: begin
                    n_direction = i_cfg_data[0];
                    o_restart   = 1'b1;
                end
                CFG_DATA_WORDS: begin
                    n_dw      = i_cfg_data[DW_W-1:0];
                    o_restart = 1'b1;
                end
                CFG_SUBCARR: begin
                    n_sc      = i_cfg_data[SC_W-1:0];
                    o_restart = 1'b1;
                end
                CFG_SYMBOLS: begin
                    n_sps     = i_cfg_data[SPS_W-1:0];
                    o_restart = 1'b1;
                end
                CFG_RSV_MASK: begin
                    n_mask    = i_cfg_data[MASK_W-1:0];
                    o_restart = 1'b1;
                end
                CFG_STRIDE: begin
                    n_stride  = i_cfg_data[STRIDE_W-1:0];
                    o_restart = 1'b1;
                end
                CFG_LAYERS: begin
                    n_nl      = i_cfg_data[NL_W-1:0];
                    o_restart = 1'b1;
                end
                default: begin
                    o_restart = 1'b0;
                end
            endcase
        end
    end

    // registers with their reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= DIR_ALLOCATE;
            r_dw        <= DW_W'(1);
            r_sc        <= SC_W'(12);
            r_sps       <= SPS_W'(14);
            r_mask      <= '0;
            r_stride    <= STRIDE_W'(1);
            r_nl        <= NL_W'(1);
        end else begin
            r_direction <= n_direction;
            r_dw        <= n_dw;
            r_sc        <= n_sc;
            r_sps       <= n_sps;
            r_mask      <= n_mask;
            r_stride    <= n_stride;
            r_nl        <= n_nl;
        end
    end

    assign o_cfg      = cfg_eff(r_direction, r_dw, r_sc, r_sps, r_mask, r_stride, r_nl);
    assign o_cfg_next = cfg_eff(n_direction, n_dw, n_sc, n_sps, n_mask, n_stride, n_nl);

endmodule

// ===== rtl/core/dmap_ctrl.sv =====
// ----------------------------------------------------------------------------
// dmap_ctrl: grid position counters and address datapath
// Tracks word, symbol, slot and layer position and forms the grid address
// (allocate) or data index (extract) of each accepted word combinationally.
// Row and layer base addresses are kept as running sums.
// ----------------------------------------------------------------------------
module dmap_ctrl import dmap_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  t_cfg              i_cfg_next,
    input  logic              i_restart,
    input  logic              i_accept,
    input  logic [WORD_W-1:0] i_word,
    output logic              o_res_valid,
    output t_result           o_res,
    output t_status           o_status
);

    logic [WIS_W-1:0]    r_wis, n_wis;
    logic [SYM_W-1:0]    r_sym, n_sym;
    logic [ROW_W-1:0]    r_grid_row, n_grid_row;
    logic [DW_W-1:0]     r_done, n_done;
    logic [LAYER_W-1:0]  r_layer, n_layer;
    logic [STRIDE_W-1:0] r_gwil, n_gwil;
    logic [ADDR_W-1:0]   r_slot_base, n_slot_base;
    logic [ADDR_W-1:0]   r_row_base, n_row_base;
    logic [ADDR_W-1:0]   r_layer_base, n_layer_base;

    logic [WIS_W-1:0]    wis_inc;
    logic                row_end;
    logic [DW_W:0]       done_inc;
    logic [STRIDE_W-1:0] gwil_inc;
    t_pick               pick;
    logic                slot_wrap;
    logic                slot_bump;
    logic [SYM_W-1:0]    sym_adv;
    logic [ADDR_W-1:0]   adv_slot_base;
    logic [ADDR_W-1:0]   adv_row_base;
    logic                layer_wrap;
    logic                emit;
    logic                do_start;
    t_cfg                st_cfg;

    // counter increments and end tests
    assign wis_inc  = r_wis + WIS_W'(1);
    assign row_end  = wis_inc >= i_cfg.row_words;
    assign done_inc = (DW_W + 1)'(r_done) + (DW_W + 1)'(1);
    assign gwil_inc = r_gwil + STRIDE_W'(1);
    assign emit     = i_cfg.free[r_sym] && (r_done < i_cfg.dw);

    // next row: next data symbol (allocate) or next symbol (extract)
    always_comb begin
        pick = first_free(i_cfg.free, (SYM_W + 1)'(r_sym) + (SYM_W + 1)'(1));
        if (i_cfg.direction == DIR_EXTRACT) begin
            slot_wrap = ((SYM_W + 1)'(r_sym) + (SYM_W + 1)'(1)) >= (SYM_W + 1)'(i_cfg.sps);
            sym_adv   = slot_wrap ? '0 : r_sym + SYM_W'(1);
        end else begin
            slot_wrap = !pick.found;
            sym_adv   = slot_wrap ? i_cfg.ff0 : pick.idx;
        end
        // slot count saturates
        slot_bump     = slot_wrap && !(&r_grid_row);
        adv_slot_base = slot_bump ? r_slot_base + ADDR_W'(i_cfg.slot_words) : r_slot_base;
        adv_row_base  = adv_slot_base + ADDR_W'(SLOT_W'(sym_adv) * SLOT_W'(i_cfg.row_words));
    end

    // next layer of the frame
    assign layer_wrap = (NL_W'(r_layer) + NL_W'(1)) >= i_cfg.nl;
    assign st_cfg     = i_restart ? i_cfg_next : i_cfg;

    // state update and result
    always_comb begin
        n_wis        = r_wis;
        n_sym        = r_sym;
        n_grid_row   = r_grid_row;
        n_done       = r_done;
        n_layer      = r_layer;
        n_gwil       = r_gwil;
        n_slot_base  = r_slot_base;
        n_row_base   = r_row_base;
        n_layer_base = r_layer_base;
        do_start     = 1'b0;
        o_res_valid  = 1'b0;
        o_res.word   = i_word;
        o_res.addr   = '0;
        o_res.last   = 1'b0;
        if (i_restart) begin
            n_layer      = '0;
            n_layer_base = '0;
            do_start     = 1'b1;
        end else if (i_accept) begin
            if (i_cfg.direction == DIR_ALLOCATE) begin
                o_res_valid = 1'b1;
                o_res.addr  = r_row_base + ADDR_W'(r_wis) + r_layer_base;
                if (done_inc >= (DW_W + 1)'(i_cfg.dw)) begin
                    o_res.last   = layer_wrap;
                    n_layer      = layer_wrap ? '0 : r_layer + LAYER_W'(1);
                    n_layer_base = layer_wrap ? '0 : r_layer_base + ADDR_W'(i_cfg.stride);
                    do_start     = 1'b1;
                end else begin
                    n_done = done_inc[DW_W-1:0];
                    if (row_end) begin
                        n_wis       = '0;
                        n_sym       = sym_adv;
                        n_grid_row  = slot_bump ? r_grid_row + ROW_W'(1) : r_grid_row;
                        n_slot_base = adv_slot_base;
                        n_row_base  = adv_row_base;
                    end else begin
                        n_wis = wis_inc;
                    end
                end
            end else begin
                o_res_valid = emit;
                o_res.addr  = r_layer_base + ADDR_W'(r_done);
                o_res.last  = emit && (done_inc == (DW_W + 1)'(i_cfg.dw)) && layer_wrap;
                if (gwil_inc >= i_cfg.stride) begin
                    n_layer      = layer_wrap ? '0 : r_layer + LAYER_W'(1);
                    n_layer_base = layer_wrap ? '0 : r_layer_base + ADDR_W'(i_cfg.dw);
                    do_start     = 1'b1;
                end else begin
                    n_gwil = gwil_inc;
                    if (emit) begin
                        n_done = done_inc[DW_W-1:0];
                    end
                    if (row_end) begin
                        n_wis       = '0;
                        n_sym       = sym_adv;
                        n_grid_row  = slot_bump ? r_grid_row + ROW_W'(1) : r_grid_row;
                        n_slot_base = adv_slot_base;
                        n_row_base  = adv_row_base;
                    end else begin
                        n_wis = wis_inc;
                    end
                end
            end
        end
        // fresh layer: first row of the grid
        if (do_start) begin
            n_wis       = '0;
            n_grid_row  = '0;
            n_done      = '0;
            n_gwil      = '0;
            n_slot_base = '0;
            n_sym       = (st_cfg.direction == DIR_EXTRACT) ? '0 : st_cfg.ff0;
            n_row_base  = (st_cfg.direction == DIR_EXTRACT) ? '0
                                                             : ADDR_W'(st_cfg.start_base);
        end
    end

    // position registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wis        <= '0;
            r_sym        <= '0;
            r_grid_row   <= '0;
            r_done       <= '0;
            r_layer      <= '0;
            r_gwil       <= '0;
            r_slot_base  <= '0;
            r_row_base   <= '0;
            r_layer_base <= '0;
        end else begin
            r_wis        <= n_wis;
            r_sym        <= n_sym;
            r_grid_row   <= n_grid_row;
            r_done       <= n_done;
            r_layer      <= n_layer;
            r_gwil       <= n_gwil;
            r_slot_base  <= n_slot_base;
            r_row_base   <= n_row_base;
            r_layer_base <= n_layer_base;
        end
    end

    assign o_status.layer = r_layer;
    assign o_status.wis   = r_wis;
    assign o_status.done  = r_done;

endmodule

// ===== rtl/core/dmap_out.sv =====
// ----------------------------------------------------------------------------
// dmap_out: result register with skid stage
// Registers each result word; a second entry catches the word accepted in
// the cycle the receiver stalls, so input ready is a plain register.
// ----------------------------------------------------------------------------
module dmap_out import dmap_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_result     i_res,
    output logic        o_ready,
    dmap_out_if.source  o_result
);

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid;
    logic    load_out;
    logic    load_skid;

    // move words between output register and skid entry
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        load_out     = 1'b0;
        load_skid    = 1'b0;
        n_out        = r_skid_valid ? r_skid : i_res;
        if (!r_out_valid || o_result.ready) begin
            n_out_valid  = r_skid_valid || i_valid;
            n_skid_valid = 1'b0;
            load_out     = 1'b1;
        end else if (i_valid) begin
            n_skid_valid = 1'b1;
            load_skid    = 1'b1;
        end
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= n_out;
        end
        if (load_skid) begin
            r_skid <= i_res;
        end
    end

    assign o_ready                 = !r_skid_valid;
    assign o_result.valid          = r_out_valid;
    assign o_result.out_word       = r_out.word;
    assign o_result.target_address = r_out.addr;
    assign o_result.frame_last     = r_out.last;

endmodule

// ===== rtl/core/ofdm_data_resource_mapper.sv =====
// ----------------------------------------------------------------------------
// ofdm_data_resource_mapper: OFDM data resource mapper top level
// Maps data words to grid addresses, or picks data words out of a grid.
// ----------------------------------------------------------------------------
// Usage:
//   i_sample carries one 32-bit word per accepted transfer: a data word in
//   allocate mode, a grid word in extract mode. o_result returns the word with
//   its grid address (allocate) or data index (extract) and a frame_last flag.
//   Extract mode drops grid words on reserved symbols and past the data count.
//   i_cfg_we writes one register per cycle; each register write restarts the
//   frame at layer 0. Write only while no word is in flight.
// Timing:
//   one word per clock sustained while the receiver takes results. The
//   position counters set throughput and advance once per accepted word. Each
//   result is held in the output register, or in the skid entry on a stall.
//   When the receiver stalls, one more word is taken into a skid entry, then
//   i_sample.ready drops until the output drains.
// Reset:
//   i_rst_n is synchronous; registers take their default values, the frame
//   starts at layer 0 and output valid is cleared. No clearing pass is needed.
// ----------------------------------------------------------------------------
module ofdm_data_resource_mapper import dmap_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    dmap_in_if.sink               i_sample,
    dmap_out_if.source            o_result
);

    t_cfg    w_cfg;
    t_cfg    w_cfg_next;
    logic    w_restart;
    logic    w_ready;
    logic    w_accept;
    logic    w_res_valid;
    t_result w_res;
    t_status w_status;

    // input handshake
    assign i_sample.ready = w_ready;
    assign w_accept       = i_sample.valid && w_ready;

    // configuration registers
    dmap_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg),
        .o_cfg_next (w_cfg_next),
        .o_restart  (w_restart)
    );

    // position counters and address
    dmap_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cfg_next  (w_cfg_next),
        .i_restart   (w_restart),
        .i_accept    (w_accept),
        .i_word      (i_sample.sample_word),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_status    (w_status)
    );

    // result register and skid entry
    dmap_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_res_valid),
        .i_res    (w_res),
        .o_ready  (w_ready),
        .o_result (o_result)
    );

    // backpressure only with a word waiting at the output
    a_ready_low_needs_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_sample.ready |-> o_result.valid)
        else $error("input stalled with empty output");

    // layer index stays inside the configured layer count
    a_layer_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (NL_W'(w_status.layer) < w_cfg.nl))
        else $error("layer index beyond layer count");

    // word position stays inside one symbol row
    a_word_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_status.wis < w_cfg.row_words))
        else $error("word position beyond symbol row");

    // allocate never sits on a finished layer
    a_alloc_done_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg.direction == DIR_ALLOCATE) |-> (w_status.done < w_cfg.dw))
        else $error("data count reached without layer change");

endmodule

// ===== bench/tb_ofdm_data_resource_mapper.sv =====
// ----------------------------------------------------------------------------
// tb_ofdm_data_resource_mapper: self-checking bench of the data resource mapper
// Drives sample words in allocate and extract mode over many grid settings,
// predicts each result word (grid address or data index, frame end) with an
// independent position tracker, and compares every accepted result in order.
// ----------------------------------------------------------------------------
module tb_ofdm_data_resource_mapper import dmap_pkg::*; ();

    // grid position tracker and store of result words still due
    class resource_map_board;
        // register copies
        logic                direction;
        logic [DW_W-1:0]     words_reg;
        logic [SC_W-1:0]     subcarr_reg;
        logic [SPS_W-1:0]    symbols_reg;
        logic [MASK_W-1:0]   rsv_mask_reg;
        logic [STRIDE_W-1:0] stride_reg;
        logic [NL_W-1:0]     layers_reg;

        // position in the frame
        int unsigned word_pos;
        int unsigned sym_pos;
        int unsigned slot_cnt;
        int unsigned data_cnt;
        int unsigned layer;
        int unsigned grid_cnt;

        t_result     due_words[$];
        int unsigned mismatches;
        int unsigned matched;
        int unsigned predicted;

        function new();
            direction    = DIR_ALLOCATE;
            words_reg    = 1;
            subcarr_reg  = 12;
            symbols_reg  = 14;
            rsv_mask_reg = '0;
            stride_reg   = 1;
            layers_reg   = 1;
            layer        = 0;
            mismatches   = 0;
            matched      = 0;
            predicted    = 0;
            start_layer();
        endfunction

        // zero registers act as one, oversized ones saturate
        function int unsigned eff_words();
            return (words_reg == 0) ? 1 : words_reg;
        endfunction

        function int unsigned eff_stride();
            return (stride_reg == 0) ? 1 : stride_reg;
        endfunction

        function int unsigned eff_row_words();
            return 2 * ((subcarr_reg == 0) ? 1 : subcarr_reg);
        endfunction

        function int unsigned eff_symbols();
            if (symbols_reg == 0) return 1;
            return (symbols_reg > MAX_SYMBOLS_PER_SLOT) ? MAX_SYMBOLS_PER_SLOT : symbols_reg;
        endfunction

        function int unsigned eff_layers();
            if (layers_reg == 0) return 1;
            return (layers_reg > MAX_LAYERS) ? MAX_LAYERS : layers_reg;
        endfunction

        // bits past the slot are ignored, a fully reserved slot carries data
        function int unsigned eff_rsv_mask();
            int unsigned full;
            int unsigned m;
            full = (1 << eff_symbols()) - 1;
            m    = rsv_mask_reg & full;
            return (m == full) ? 0 : m;
        endfunction

        function bit sym_is_data(int unsigned s);
            return (s < 16) && (((eff_rsv_mask() >> s) & 1) == 0);
        endfunction

        function int unsigned next_data_sym(int unsigned from);
            for (int unsigned s = from; s < eff_symbols(); s++)
                if (sym_is_data(s)) return s;
            return eff_symbols();
        endfunction

        function void bump_slot();
            if (slot_cnt < 65535) slot_cnt++;
        endfunction

        function void start_layer();
            word_pos = 0;
            slot_cnt = 0;
            data_cnt = 0;
            grid_cnt = 0;
            sym_pos  = (direction == DIR_EXTRACT) ? 0 : next_data_sym(0);
        endfunction

        // register write restarts the frame
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_DIRECTION:  direction    = val[0];
                CFG_DATA_WORDS: words_reg    = val[DW_W-1:0];
                CFG_SUBCARR:    subcarr_reg  = val[SC_W-1:0];
                CFG_SYMBOLS:    symbols_reg  = val[SPS_W-1:0];
                CFG_RSV_MASK:   rsv_mask_reg = val[MASK_W-1:0];
                CFG_STRIDE:     stride_reg   = val[STRIDE_W-1:0];
                CFG_LAYERS:     layers_reg   = val[NL_W-1:0];
                default:        return;
            endcase
            layer = 0;
            start_layer();
        endfunction

        // advance the position by one accepted word, queue its result if any
        function void note_sample(logic [WORD_W-1:0] w);
            int unsigned     dw;
            int unsigned     nl;
            int unsigned     rw;
            int unsigned     s;
            bit              last;
            bit              emit;
            longint unsigned row;
            longint unsigned addr;
            t_result         r;
            dw   = eff_words();
            nl   = eff_layers();
            rw   = eff_row_words();
            last = 0;
            addr = 0;
            if (layer >= nl) begin
                layer = 0;
                start_layer();
            end
            if (direction == DIR_ALLOCATE) begin
                row  = 64'(slot_cnt) * eff_symbols() + sym_pos;
                addr = row * rw + word_pos + 64'(layer) * eff_stride();
                emit = 1;
                data_cnt++;
                word_pos++;
                // next data row, skipping reserved symbols and wrapping the slot
                if (word_pos >= rw) begin
                    word_pos = 0;
                    s = next_data_sym(sym_pos + 1);
                    if (s >= eff_symbols()) begin
                        bump_slot();
                        s = next_data_sym(0);
                    end
                    sym_pos = s;
                end
                if (data_cnt >= dw) begin
                    layer++;
                    if (layer >= nl) begin
                        layer = 0;
                        last  = 1;
                    end
                    start_layer();
                end
            end else begin
                emit = sym_is_data(sym_pos) && (data_cnt < dw);
                if (emit) begin
                    addr = 64'(layer) * dw + data_cnt;
                    data_cnt++;
                    if (data_cnt == dw && layer == nl - 1) last = 1;
                end
                word_pos++;
                // every grid row counts, reserved or not
                if (word_pos >= rw) begin
                    word_pos = 0;
                    sym_pos++;
                    if (sym_pos >= eff_symbols()) begin
                        sym_pos = 0;
                        bump_slot();
                    end
                end
                grid_cnt++;
                if (grid_cnt >= eff_stride()) begin
                    layer++;
                    if (layer >= nl) layer = 0;
                    start_layer();
                end
            end
            if (emit) begin
                r.word = w;
                r.addr = addr[ADDR_W-1:0];
                r.last = last;
                due_words.push_back(r);
                predicted++;
            end
        endfunction

        // compare one result word with the oldest one due
        function void check_mapping(logic [WORD_W-1:0] w, logic [ADDR_W-1:0] a, logic l);
            t_result r;
            if (due_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: word %h addr %h last %0b", w, a, l);
                return;
            end
            r = due_words.pop_front();
            if (r.word !== w || r.addr !== a || r.last !== l) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected word %h addr %h last %0b, got word %h addr %h last %0b",
                             r.word, r.addr, r.last, w, a, l);
            end else begin
                matched++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    dmap_in_if  in_ch ();
    dmap_out_if out_ch ();

    resource_map_board board;
    int unsigned       src_idle_pct;
    int unsigned       snk_idle_pct;
    int unsigned       settings_done;
    int unsigned       words_sent;

    ofdm_data_resource_mapper dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (in_ch.sink),
        .o_result   (out_ch.source)
    );

    // clock, period 2
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // receiver back pressure
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready = ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // result word check
    initial begin
        forever begin
            @(posedge i_clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                board.check_mapping(out_ch.out_word, out_ch.target_address, out_ch.frame_last);
        end
    end

    // send one word, with random gaps before it
    task automatic send_word(input logic [WORD_W-1:0] w);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       = 1'b1;
        in_ch.sample_word = w;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        board.note_sample(w);
        words_sent++;
        @(negedge i_clk);
    endtask

    // wait until the block has drained before touching registers
    task automatic settle();
        in_ch.valid = 1'b0;
        while (board.due_words.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        board.write_reg(idx, val[CFG_DATA_W-1:0]);
        @(negedge i_clk);
    endtask

    task automatic program_grid(input int unsigned dir, input int unsigned dw,
                                input int unsigned sc, input int unsigned sps,
                                input int unsigned mask, input int unsigned stride,
                                input int unsigned nl);
        settle();
        cfg_write(CFG_DIRECTION, dir);
        cfg_write(CFG_DATA_WORDS, dw);
        cfg_write(CFG_SUBCARR, sc);
        cfg_write(CFG_SYMBOLS, sps);
        cfg_write(CFG_RSV_MASK, mask);
        cfg_write(CFG_STRIDE, stride);
        cfg_write(CFG_LAYERS, nl);
        i_cfg_we = 1'b0;
        settings_done++;
    endtask

    // one random setting and a burst of words; grids mostly sized to hold the data
    task automatic random_phase(input int unsigned base);
        int unsigned dir;
        int unsigned dw;
        int unsigned sc;
        int unsigned sps;
        int unsigned mask;
        int unsigned stride;
        int unsigned nl;
        int unsigned dw_e;
        int unsigned sc_e;
        int unsigned sps_e;
        int unsigned n_words;
        int unsigned pick;
        int unsigned got;
        dir  = $urandom_range(1) ? DIR_EXTRACT : DIR_ALLOCATE;
        pick = $urandom_range(99);
        dw   = (pick < 8) ? 0 : (pick < 12) ? 65535 : $urandom_range(24, 1);
        pick = $urandom_range(99);
        sc   = (pick < 8) ? 0 : (pick < 12) ? 4095 : $urandom_range(4, 1);
        pick = $urandom_range(99);
        sps  = (pick < 8) ? 0 : (pick < 18) ? 15 : $urandom_range(14, 1);
        pick = $urandom_range(99);
        mask = (pick < 12) ? 'h3FFF : $urandom_range('h3FFF);
        pick = $urandom_range(99);
        nl   = (pick < 8) ? 0 : (pick < 16) ? $urandom_range(15, 9) : $urandom_range(4, 1);
        dw_e  = (dw == 0) ? 1 : dw;
        sc_e  = (sc == 0) ? 1 : sc;
        sps_e = (sps == 0) ? 1 : (sps > 14) ? 14 : sps;
        pick  = $urandom_range(99);
        if (pick < 5)
            stride = 0;
        else if (pick < 8)
            stride = 'hFFFFFF;
        else if (pick < 20)
            stride = $urandom_range(12, 1);
        else
            stride = (dw_e + 2 * sc_e) * sps_e + $urandom_range(6);
        if (stride > 'hFFFFFF) stride = 'hFFFFFF;
        program_grid(dir, dw, sc, sps, mask, stride, nl);
        n_words = (dir == DIR_EXTRACT) ? $urandom_range(90, 20) : $urandom_range(40, 8);
        repeat (n_words) begin
            // idle pattern follows how far the random part has got
            got = words_sent - base;
            if (got < 117) begin
                src_idle_pct = 31;
                snk_idle_pct = 74;
            end else if (got < 234) begin
                src_idle_pct = 74;
                snk_idle_pct = 31;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            send_word($urandom);
        end
        in_ch.valid = 1'b0;
    endtask

    // stimulus
    initial begin
        int unsigned base;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_data        = '0;
        in_ch.valid       = 1'b0;
        in_ch.sample_word = '0;
        src_idle_pct      = 31;
        snk_idle_pct      = 74;
        settings_done     = 0;
        words_sent        = 0;
        board             = new();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: every word is a whole frame
        send_word('0);
        send_word('1);
        in_ch.valid = 1'b0;

        // allocate with a partial last row running into the next slot
        program_grid(DIR_ALLOCATE, 5, 1, 4, 'b0101, 100, 2);
        repeat (8) send_word($urandom);
        in_ch.valid = 1'b0;

        // extract with mask bits past the slot, words past the data count dropped
        program_grid(DIR_EXTRACT, 3, 1, 3, 'b11010, 6, 2);
        for (int i = 0; i < 12; i++) send_word(i[0] ? 32'hA5A5_5A5A : 32'h5A5A_A5A5);
        in_ch.valid = 1'b0;

        // all registers at their top, fully reserved slot, oversized counts
        program_grid(DIR_ALLOCATE, 65535, 4095, 15, 'h3FFF, 'hFFFFFF, 15);
        repeat (3) send_word($urandom);
        in_ch.valid = 1'b0;

        base = words_sent;
        while (words_sent - base < 350) random_phase(base);

        settle();
        repeat (8) @(negedge i_clk);
        $display("%0d words in, %0d result words checked, %0d register settings in both modes",
                 words_sent, board.matched + board.mismatches, settings_done);
        if (board.mismatches == 0 && board.due_words.size() == 0) begin
            $display("[ofdm_data_resource_mapper] OK");
        end else begin
            $display("%0d mismatches, %0d result words never seen",
                     board.mismatches, board.due_words.size());
            $display("[ofdm_data_resource_mapper] ERROR");
        end
        $finish;
    end

    // hang guard
    initial begin
        #200000;
        $display("[ofdm_data_resource_mapper] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/dmap_pkg.sv
rtl/core/dmap_in_if.sv
rtl/core/dmap_out_if.sv
rtl/core/dmap_cfg.sv
rtl/core/dmap_ctrl.sv
rtl/core/dmap_out.sv
rtl/core/ofdm_data_resource_mapper.sv
bench/tb_ofdm_data_resource_mapper.sv
